/* rtl/ffr_pkg.sv */
// shared types and codes for the frame fragment reassembly core
package ffr_pkg;

  localparam logic [2:0] STAT_ACCEPTED = 3'd0;
  localparam logic [2:0] STAT_SIZE_ERR = 3'd1;
  localparam logic [2:0] STAT_RANGE_ERR = 3'd2;
  localparam logic [2:0] STAT_DELIVERED = 3'd3;
  localparam logic [2:0] STAT_SKIPPED = 3'd4;
  localparam logic [2:0] STAT_TIMEOUT = 3'd5;
  localparam logic [2:0] STAT_EVICTED = 3'd6;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam int MAX_TICK_RESULTS = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FETCH,
    ST_LOAD,
    ST_EVICT,
    ST_ACCEPT,
    ST_DONE,
    ST_TSCAN,
    ST_TREAD,
    ST_TEMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [20:0] buffer_address;
    logic [16:0] frame_length;
    logic [31:0] frame_sequence;
    logic [31:0] frame_time;
    logic        frame_is_keyframe;
    logic [31:0] recv_count;
    logic [31:0] drop_count;
    logic [31:0] timeouts_seen;
    logic        last;
  } result_t;

endpackage

/* rtl/ffr_slot_ram.sv */
// slot table memory, one write port and one registered read port
module ffr_slot_ram import ffr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/frame_fragment_reassembly_core.sv */
// frame fragment reassembly table: slot matching, completion and timeouts
//
//  channel  | direction | contents
//  s_axis   | in        | fragment descriptor or tick request
//  m_axis   | out       | result requests, tlast on the final one of an input
//  cfg      | in        | timeout_ticks write
//
// a rejected fragment goes from ST_IDLE through ST_CHECK straight back to ST_IDLE
// a fragment walks the slot memory once in ST_SCAN, then reads the chosen slot in
// ST_FETCH and ST_LOAD, plus ST_EVICT for an eviction and ST_DONE for a completion
// a tick walks every slot in ST_TSCAN, then rereads each slot up to the last stale
// one through ST_TREAD and ST_TEMIT; the single read port sets this
// rst is synchronous; valid bits and counters clear, slot memory is not cleared
// a stalled m_axis holds the walk at its current result; cfg_ready is always high
module frame_fragment_reassembly_core import ffr_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int MAX_FRAGMENTS = 64,
  parameter int SLOT_BYTES = 131072
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sequence_number, fragment_index, byte_offset, declared_size,
  // actual_payload_size, keyframe_flag, capture_time
  input  logic [135:0] s_axis_tdata,
  // cmd
  input  logic [0:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot_index, buffer_address, frame_length, frame_sequence, frame_time,
  // frame_is_keyframe, recv_count, drop_count, timeouts_seen
  output logic [207:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int FW = $clog2(MAX_FRAGMENTS);
  localparam int TCW = $clog2(MAX_FRAGMENTS + 1);
  localparam int PW = SW + 19;
  localparam logic [17:0] SB = 18'(SLOT_BYTES);
  localparam logic [SW:0] CNT_END = (SW+1)'(SLOTS);

  typedef struct packed {
    logic [31:0]              seq;
    logic [MAX_FRAGMENTS-1:0] bitmap;
    logic                     tk;
    logic [TCW-1:0]           tc;
    logic [16:0]              len;
    logic [31:0]              ftime;
    logic                     key;
    logic [31:0]              touched;
  } entry_t;

  localparam int EW = $bits(entry_t);

  state_t state, state_next;

  logic [SLOTS-1:0] valid, valid_next;
  logic [SW:0]      cnt, cnt_next;
  logic             chk_vld, chk_vld_next;
  logic [SW-1:0]    chk_idx, chk_idx_next;
  logic             hit, hit_next;
  logic [SW-1:0]    hit_idx, hit_idx_next;
  logic [31:0]      min_seq, min_seq_next;
  logic [SW-1:0]    min_idx, min_idx_next;
  logic [SW-1:0]    sel, sel_next;
  logic             evict, evict_next;
  logic             fresh, fresh_next;
  entry_t           ent, ent_next;
  logic [SW-1:0]    last_stale, last_stale_next;
  logic [4:0]       stale_cnt, stale_cnt_next;
  logic             any_stale, any_stale_next;

  logic [31:0] in_seq;
  logic [15:0] in_idx, in_off, in_dsz, in_asz;
  logic        in_key, in_lastf;
  logic [31:0] in_time;

  logic [15:0] timeout_ticks;
  logic [31:0] tick_now, tick_now_next;
  logic        keyframe_seen, keyframe_seen_next;
  logic [31:0] expected_next, expected_next_next;
  logic [31:0] rcv, rcv_next, drp, drp_next, tmo, tmo_next;

  result_t res, res_next;
  logic    out_vld, out_vld_next;

  logic          mem_we, mem_re;
  logic [SW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;
  logic [EW-1:0] mem_rdata;
  entry_t        rd;

  logic          out_free, emit;
  logic          in_take;
  logic          size_bad, range_bad;
  logic [16:0]   end_pos;
  logic          free_any;
  logic [SW-1:0] free_idx, pick;
  logic          stale;
  entry_t        fresh_ent, upd;
  logic [MAX_FRAGMENTS-1:0] need;
  logic          complete;
  logic [PW-1:0] addr_full;
  logic [SW-1:0] ridx;

  ffr_slot_ram #(.DEPTH(SLOTS), .WIDTH(EW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd = entry_t'(mem_rdata);
  assign out_free = !out_vld || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  assign size_bad = (in_dsz != in_asz);
  assign end_pos = {1'b0, in_off} + {1'b0, in_asz};
  assign range_bad = (in_idx >= 16'(MAX_FRAGMENTS)) || ({1'b0, end_pos} > SB);

  assign ridx = (state == ST_TEMIT) ? cnt[SW-1:0] : chk_idx;
  assign stale = valid[ridx] && ((tick_now - rd.touched) > {16'd0, timeout_ticks});

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign pick = hit ? hit_idx : (free_any ? free_idx : min_idx);

  always_comb begin
    fresh_ent = '0;
    fresh_ent.seq = in_seq;
    fresh_ent.ftime = in_time;
    fresh_ent.key = in_key;
  end

  always_comb begin
    upd = ent;
    upd.touched = tick_now;
    upd.bitmap = ent.bitmap | (MAX_FRAGMENTS'(1) << in_idx[FW-1:0]);
    if (end_pos > ent.len) begin
      upd.len = end_pos;
    end
    if (in_lastf) begin
      upd.tk = 1'b1;
      upd.tc = TCW'(in_idx) + TCW'(1);
    end
  end

  always_comb begin
    for (int b = 0; b < MAX_FRAGMENTS; b++) begin
      need[b] = (upd.tc > TCW'(b));
    end
  end

  assign complete = upd.tk && (&(~need | upd.bitmap));
  assign addr_full = (PW'(sel) * PW'(SB)) + PW'(in_off);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = s_axis_tuser[0] ? ST_TSCAN : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (size_bad || range_bad) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == CNT_END) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD: state_next = evict ? ST_EVICT : ST_ACCEPT;
      ST_EVICT: begin
        if (out_free) begin
          state_next = ST_ACCEPT;
        end
      end
      ST_ACCEPT: begin
        if (out_free) begin
          state_next = complete ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TSCAN: begin
        if (cnt == CNT_END) begin
          state_next = (any_stale || (chk_vld && stale)) ? ST_TREAD : ST_IDLE;
        end
      end
      ST_TREAD: state_next = ST_TEMIT;
      ST_TEMIT: begin
        if (!stale || out_free) begin
          state_next = (cnt[SW-1:0] == last_stale) ? ST_IDLE : ST_TREAD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    valid_next = valid;
    cnt_next = cnt;
    chk_vld_next = 1'b0;
    chk_idx_next = chk_idx;
    hit_next = hit;
    hit_idx_next = hit_idx;
    min_seq_next = min_seq;
    min_idx_next = min_idx;
    sel_next = sel;
    evict_next = evict;
    fresh_next = fresh;
    ent_next = ent;
    last_stale_next = last_stale;
    stale_cnt_next = stale_cnt;
    any_stale_next = any_stale;
    tick_now_next = tick_now;
    keyframe_seen_next = keyframe_seen;
    expected_next_next = expected_next;
    rcv_next = rcv;
    drp_next = drp;
    tmo_next = tmo;
    emit = 1'b0;
    res_next = res;
    mem_we = 1'b0;
    mem_waddr = sel;
    mem_wdata = upd;
    mem_re = 1'b0;
    mem_raddr = cnt[SW-1:0];

    case (state)
      ST_IDLE: begin
        if (in_take && s_axis_tuser[0]) begin
          tick_now_next = tick_now + 32'd1;
        end
        cnt_next = '0;
        hit_next = 1'b0;
        min_idx_next = '0;
        stale_cnt_next = '0;
        any_stale_next = 1'b0;
      end
      ST_CHECK: begin
        if ((size_bad || range_bad) && out_free) begin
          emit = 1'b1;
          res_next = '0;
          res_next.status = size_bad ? STAT_SIZE_ERR : STAT_RANGE_ERR;
          res_next.frame_sequence = in_seq;
          res_next.recv_count = rcv;
          res_next.drop_count = drp;
          res_next.timeouts_seen = tmo;
          res_next.last = 1'b1;
        end
      end
      ST_SCAN, ST_TSCAN: begin
        if (cnt != CNT_END) begin
          mem_re = 1'b1;
          chk_vld_next = 1'b1;
          chk_idx_next = cnt[SW-1:0];
          cnt_next = cnt + (SW+1)'(1);
        end else begin
          cnt_next = '0;
        end
        if (chk_vld) begin
          if (state == ST_SCAN) begin
            if (!hit && valid[chk_idx] && (rd.seq == in_seq)) begin
              hit_next = 1'b1;
              hit_idx_next = chk_idx;
            end
            if ((chk_idx == '0) || (rd.seq < min_seq)) begin
              min_seq_next = rd.seq;
              min_idx_next = chk_idx;
            end
          end else if (stale && (stale_cnt < 5'(MAX_TICK_RESULTS))) begin
            stale_cnt_next = stale_cnt + 5'd1;
            last_stale_next = chk_idx;
            any_stale_next = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        sel_next = pick;
        evict_next = !hit && !free_any;
        fresh_next = !hit;
        mem_re = 1'b1;
        mem_raddr = pick;
      end
      ST_LOAD: begin
        ent_next = (fresh && !evict) ? fresh_ent : rd;
      end
      ST_EVICT: begin
        if (out_free) begin
          emit = 1'b1;
          res_next.status = STAT_EVICTED;
          res_next.slot_index = 4'(sel);
          res_next.buffer_address = '0;
          res_next.frame_length = ent.len;
          res_next.frame_sequence = ent.seq;
          res_next.frame_time = ent.ftime;
          res_next.frame_is_keyframe = ent.key;
          res_next.recv_count = rcv;
          res_next.drop_count = drp;
          res_next.timeouts_seen = tmo;
          res_next.last = 1'b0;
          ent_next = fresh_ent;
        end
      end
      ST_ACCEPT: begin
        if (out_free) begin
          emit = 1'b1;
          mem_we = 1'b1;
          valid_next[sel] = 1'b1;
          ent_next = upd;
          res_next.status = STAT_ACCEPTED;
          res_next.slot_index = 4'(sel);
          res_next.buffer_address = addr_full[20:0];
          res_next.frame_length = upd.len;
          res_next.frame_sequence = upd.seq;
          res_next.frame_time = upd.ftime;
          res_next.frame_is_keyframe = upd.key;
          res_next.recv_count = rcv;
          res_next.drop_count = drp;
          res_next.timeouts_seen = tmo;
          res_next.last = !complete;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          valid_next[sel] = 1'b0;
          keyframe_seen_next = keyframe_seen || ent.key;
          rcv_next = rcv + 32'd1;
          if ((expected_next != 32'd0) && (in_seq != expected_next)) begin
            drp_next = drp + (in_seq - expected_next);
          end
          expected_next_next = in_seq + 32'd1;
          res_next.status = keyframe_seen_next ? STAT_DELIVERED : STAT_SKIPPED;
          res_next.slot_index = 4'(sel);
          res_next.buffer_address = '0;
          res_next.frame_length = ent.len;
          res_next.frame_sequence = ent.seq;
          res_next.frame_time = ent.ftime;
          res_next.frame_is_keyframe = ent.key;
          res_next.recv_count = rcv_next;
          res_next.drop_count = drp_next;
          res_next.timeouts_seen = tmo;
          res_next.last = 1'b1;
        end
      end
      ST_TREAD: begin
        mem_re = 1'b1;
      end
      ST_TEMIT: begin
        if (stale && out_free) begin
          emit = 1'b1;
          valid_next[cnt[SW-1:0]] = 1'b0;
          tmo_next = tmo + 32'd1;
          drp_next = drp + 32'd1;
          res_next.status = STAT_TIMEOUT;
          res_next.slot_index = 4'(cnt[SW-1:0]);
          res_next.buffer_address = '0;
          res_next.frame_length = rd.len;
          res_next.frame_sequence = rd.seq;
          res_next.frame_time = rd.ftime;
          res_next.frame_is_keyframe = rd.key;
          res_next.recv_count = rcv;
          res_next.drop_count = drp_next;
          res_next.timeouts_seen = tmo_next;
          res_next.last = (cnt[SW-1:0] == last_stale);
        end
        if (!stale || out_free) begin
          cnt_next = cnt + (SW+1)'(1);
        end
      end
      default: begin
      end
    endcase

    out_vld_next = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      chk_vld <= 1'b0;
      out_vld <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
      tick_now <= '0;
      keyframe_seen <= 1'b0;
      expected_next <= '0;
      rcv <= '0;
      drp <= '0;
      tmo <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      chk_vld <= chk_vld_next;
      out_vld <= out_vld_next;
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
      tick_now <= tick_now_next;
      keyframe_seen <= keyframe_seen_next;
      expected_next <= expected_next_next;
      rcv <= rcv_next;
      drp <= drp_next;
      tmo <= tmo_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    chk_idx <= chk_idx_next;
    hit <= hit_next;
    hit_idx <= hit_idx_next;
    min_seq <= min_seq_next;
    min_idx <= min_idx_next;
    sel <= sel_next;
    evict <= evict_next;
    fresh <= fresh_next;
    ent <= ent_next;
    last_stale <= last_stale_next;
    stale_cnt <= stale_cnt_next;
    any_stale <= any_stale_next;
    res <= res_next;
    if (in_take) begin
      in_seq <= s_axis_tdata[31:0];
      in_idx <= s_axis_tdata[47:32];
      in_off <= s_axis_tdata[63:48];
      in_dsz <= s_axis_tdata[79:64];
      in_asz <= s_axis_tdata[95:80];
      in_key <= s_axis_tdata[96];
      in_time <= s_axis_tdata[128:97];
      in_lastf <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {5'd0, res.timeouts_seen, res.drop_count, res.recv_count,
                         res.frame_is_keyframe, res.frame_time, res.frame_sequence,
                         res.frame_length, res.buffer_address, res.slot_index};

endmodule

/* sim/tb_frame_fragment_reassembly_core.sv */
// testbench for the frame fragment reassembly core: self-predicting stream checker
`timescale 1ns / 100ps

module tb_frame_fragment_reassembly_core import ffr_pkg::*; ();

  localparam int NSLOT = 16;
  localparam int NFRAG = 64;
  localparam int SBYTES = 131072;
  localparam int DRAIN = 80;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic        cmd;
    logic [31:0] seq;
    logic [15:0] idx;
    logic [15:0] off;
    logic [15:0] dsz;
    logic [15:0] asz;
    logic        key;
    logic        lastf;
    logic [31:0] ctime;
  } frag_req_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [207:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  frame_fragment_reassembly_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] tmo_ticks;
  logic        sv_valid[NSLOT];
  logic [31:0] sv_seq[NSLOT];
  logic [63:0] sv_bits[NSLOT];
  logic        sv_tknown[NSLOT];
  logic [6:0]  sv_tcount[NSLOT];
  logic [16:0] sv_len[NSLOT];
  logic [31:0] sv_time[NSLOT];
  logic        sv_key[NSLOT];
  logic [31:0] sv_touch[NSLOT];
  logic [31:0] now_tick, next_seq, n_recv, n_drop, n_tmo;
  logic        key_seen;

  frag_req_t pending[$];
  result_t   expected_results[$];
  frag_req_t shown;
  int        errs = 0;
  bit        quiet = 0;
  int        hold_req = 0;
  int        idle_cycles = 0;

  function automatic result_t mk(logic [2:0] st, logic [3:0] sl, logic [20:0] ad,
                                 logic [16:0] ln, logic [31:0] sq, logic [31:0] tm,
                                 logic ky);
    result_t r;
    r.status = st; r.slot_index = sl; r.buffer_address = ad; r.frame_length = ln;
    r.frame_sequence = sq; r.frame_time = tm; r.frame_is_keyframe = ky;
    r.recv_count = n_recv; r.drop_count = n_drop; r.timeouts_seen = n_tmo;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_slot(logic [2:0] st, int s);
    return mk(st, s[3:0], '0, sv_len[s], sv_seq[s], sv_time[s], sv_key[s]);
  endfunction

  task automatic reassemble(input frag_req_t q);
    result_t outs[$];
    int s;
    logic [16:0] fin;
    logic [63:0] need;
    s = NSLOT;
    fin = {1'b0, q.off} + {1'b0, q.asz};
    if (q.cmd) begin
      now_tick = now_tick + 1;
      for (int i = 0; i < NSLOT; i++)
        if (sv_valid[i] && (now_tick - sv_touch[i]) > {16'd0, tmo_ticks}) begin
          sv_valid[i] = 1'b0;
          n_tmo = n_tmo + 1;
          n_drop = n_drop + 1;
          outs.push_back(mk_slot(STAT_TIMEOUT, i));
        end
    end else if (q.dsz != q.asz) begin
      outs.push_back(mk(STAT_SIZE_ERR, '0, '0, '0, q.seq, '0, 1'b0));
    end else if (q.idx >= NFRAG || fin > SBYTES) begin
      outs.push_back(mk(STAT_RANGE_ERR, '0, '0, '0, q.seq, '0, 1'b0));
    end else begin
      for (int i = 0; i < NSLOT; i++)
        if (s == NSLOT && sv_valid[i] && sv_seq[i] == q.seq) s = i;
      if (s == NSLOT) begin
        for (int i = 0; i < NSLOT; i++)
          if (s == NSLOT && !sv_valid[i]) s = i;
        if (s == NSLOT) begin
          s = 0;
          for (int i = 1; i < NSLOT; i++)
            if (sv_seq[i] < sv_seq[s]) s = i;
          outs.push_back(mk_slot(STAT_EVICTED, s));
        end
        sv_valid[s] = 1'b1; sv_seq[s] = q.seq; sv_bits[s] = '0; sv_tknown[s] = 1'b0;
        sv_tcount[s] = '0; sv_len[s] = '0; sv_time[s] = q.ctime; sv_key[s] = q.key;
      end
      sv_touch[s] = now_tick;
      sv_bits[s][q.idx[5:0]] = 1'b1;
      if (fin > sv_len[s]) sv_len[s] = fin;
      if (q.lastf) begin
        sv_tknown[s] = 1'b1;
        sv_tcount[s] = q.idx[6:0] + 7'd1;
      end
      outs.push_back(mk(STAT_ACCEPTED, s[3:0], 21'(s * SBYTES + q.off), sv_len[s],
                        q.seq, sv_time[s], sv_key[s]));
      if (sv_tknown[s]) begin
        need = (sv_tcount[s] >= 64) ? '1 : ((64'd1 << sv_tcount[s]) - 64'd1);
        if ((sv_bits[s] & need) == need) begin
          if (sv_key[s]) key_seen = 1'b1;
          n_recv = n_recv + 1;
          if (next_seq != 0 && q.seq != next_seq) n_drop = n_drop + (q.seq - next_seq);
          next_seq = q.seq + 1;
          sv_valid[s] = 1'b0;
          outs.push_back(mk_slot(key_seen ? STAT_DELIVERED : STAT_SKIPPED, s));
        end
      end
    end
    if (outs.size() > 0) outs[$].last = 1'b1;
    foreach (outs[k]) expected_results.push_back(outs[k]);
  endtask

  // request driver
  always @(posedge clk) begin
    static int gap = 0;
    frag_req_t nx;
    logic nv;
    nx = shown;
    nv = s_axis_tvalid;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        reassemble(shown);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap > 0) gap--;
        else if (pending.size() > 0) begin
          nx = pending.pop_front();
          nv = 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
        end
      end
    end
    shown <= nx;
    s_axis_tvalid <= nv;
    s_axis_tdata <= {7'd0, nx.ctime, nx.key, nx.asz, nx.dsz, nx.off, nx.idx, nx.seq};
    s_axis_tuser <= nx.cmd;
    s_axis_tlast <= nx.lastf;
  end

  // result monitor
  always @(posedge clk) begin
    static int stall = 0;
    static int hold = 0;
    result_t got, want;
    logic rdy;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.slot_index = m_axis_tdata[3:0];
      got.buffer_address = m_axis_tdata[24:4];
      got.frame_length = m_axis_tdata[41:25];
      got.frame_sequence = m_axis_tdata[73:42];
      got.frame_time = m_axis_tdata[105:74];
      got.frame_is_keyframe = m_axis_tdata[106];
      got.recv_count = m_axis_tdata[138:107];
      got.drop_count = m_axis_tdata[170:139];
      got.timeouts_seen = m_axis_tdata[202:171];
      got.last = m_axis_tlast;
      if (expected_results.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          errs++;
          if (errs <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
    if (hold_req > 0 && hold == 0) begin
      hold = hold_req;
      hold_req = 0;
    end
    if (hold > 0) begin
      hold--;
      rdy = 1'b0;
    end else if (stall > 0) begin
      stall--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 13);
    end
    m_axis_tready <= rst ? 1'b0 : rdy;
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic frag(input logic [31:0] sq, input logic [15:0] ix, input logic [15:0] of,
                      input logic [15:0] ds, input logic [15:0] as, input logic ky,
                      input logic lf, input logic [31:0] tm);
    frag_req_t q;
    q.cmd = 1'b0; q.seq = sq; q.idx = ix; q.off = of; q.dsz = ds; q.asz = as;
    q.key = ky; q.lastf = lf; q.ctime = tm;
    pending.push_back(q);
  endtask

  task automatic tick();
    frag_req_t q;
    q.cmd = 1'b1; q.seq = $urandom; q.idx = 16'($urandom); q.off = 16'($urandom);
    q.dsz = 16'($urandom); q.asz = 16'($urandom); q.key = 1'($urandom);
    q.lastf = 1'($urandom); q.ctime = $urandom;
    pending.push_back(q);
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending.size() != 0 || s_axis_tvalid || expected_results.size() != 0 ||
           !s_axis_tready)
      @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tmo_ticks = v;
  endtask

  // one well-formed frame of n fragments in shuffled order
  task automatic frame(input logic [31:0] sq, input int n, input logic ky);
    int order[$];
    logic [31:0] tm;
    logic [15:0] sz;
    tm = $urandom;
    for (int i = 0; i < n; i++) order.push_back(i);
    order.shuffle();
    foreach (order[k]) begin
      sz = 16'($urandom_range(1, 1000));
      frag(sq, 16'(order[k]), 16'(order[k] * 1000), sz, sz, ky, order[k] == n - 1, tm);
    end
  endtask

  initial begin
    logic [31:0] sq;
    logic [15:0] sz;
    tmo_ticks = TIMEOUT_RESET;
    for (int i = 0; i < NSLOT; i++) sv_valid[i] = 1'b0;
    now_tick = 0; next_seq = 0; n_recv = 0; n_drop = 0; n_tmo = 0; key_seen = 1'b0;
    shown = '{default: '0};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: rejects, extremes, skip before keyframe, gap, repeated last
    frag(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    frag(32'd7, 16'd64, 16'd0, 16'd10, 16'd10, 1'b0, 1'b0, 32'd0);
    frag(32'd7, 16'hFFFF, 16'd0, 16'd10, 16'd10, 1'b0, 1'b0, 32'd0);
    frag(32'd7, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd0);
    frag(32'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'd0);
    frag(32'd5, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 32'h1234_5678);
    frag(32'd6, 16'd1, 16'd100, 16'd50, 16'd50, 1'b0, 1'b1, 32'hA5A5_A5A5);
    frag(32'd6, 16'd2, 16'd200, 16'd50, 16'd50, 1'b0, 1'b1, 32'hA5A5_A5A5);
    frag(32'd6, 16'd0, 16'd0, 16'd100, 16'd100, 1'b0, 1'b0, 32'hA5A5_A5A5);
    frag(32'd9, 16'd63, 16'd6300, 16'd10, 16'd10, 1'b1, 1'b1, 32'h5A5A_5A5A);
    frame(32'd9, 63, 1'b1);
    frame(32'd12, 2, 1'b0);
    settle();

    // fill every slot, then force evictions and timeouts with a timeout of one tick
    write_timeout(16'd1);
    for (int i = 0; i < 18; i++)
      frag(32'd100 + 32'(17 - i), 16'd1, 16'd0, 16'd4, 16'd4, 1'b0, 1'b0, 32'(i));
    tick(); tick(); tick();
    settle();
    write_timeout(16'hFFFF);
    tick();
    settle();

    // random phase with a long receiver hold-off
    write_timeout(16'd3);
    sq = 32'd200;
    hold_req = 400;
    while (pending.size() < 10) begin
      case ($urandom_range(0, 9))
        0: tick();
        1: begin
          sz = 16'($urandom);
          frag($urandom, 16'($urandom), 16'($urandom), sz, 16'($urandom), 1'($urandom),
               1'($urandom), $urandom);
        end
        2: frag(sq, 16'($urandom_range(0, NFRAG - 1)), 16'($urandom),
                16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 1'($urandom),
                1'($urandom), $urandom);
        default: begin
          if ($urandom_range(0, 3) == 0) sq = sq + $urandom_range(1, 5);
          if ($urandom_range(0, 9) == 0) sq = $urandom;
          frame(sq, $urandom_range(1, 6), $urandom_range(0, 2) == 0);
          sq = sq + 1;
          if ($urandom_range(0, 2) == 0) tick();
        end
      endcase
    end
    settle();

    // last part without idling
    write_timeout(TIMEOUT_RESET);
    quiet = 1;
    for (int i = 0; i < 3; i++) begin
      frame(sq, $urandom_range(1, 4), 1'($urandom));
      sq = sq + 1;
      tick();
    end
    settle();

    if (errs == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
